FILE: src/bpfa_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the bitmap page frame allocator
package bpfa_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_IDX_W = 6;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned COUNT_W   = 15;

  localparam logic [ADDR_W-1:0] LOW_RESERVED_BYTES = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] KERNEL_END_RESET   = 32'h0010_0000;

  // request kinds
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // result codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_OOM     = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    WU_FILL,
    WU_SET_LOWEST,
    WU_CLEAR_BIT
  } wu_op_e;

  typedef struct packed {
    logic                 full;
    logic [BIT_IDX_W-1:0] zero_pos;
  } word_stat_t;

endpackage

FILE: src/bpfa_map_ram.sv
`timescale 1ns / 1ps
// bitmap storage, one write port and one registered read port
module bpfa_map_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  bpfa_pkg::word_t   wr_word_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output bpfa_pkg::word_t   rd_word_o
);

  bpfa_pkg::word_t mem_q [DEPTH];
  bpfa_pkg::word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_word_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_word_o = rd_q;

endmodule

FILE: src/bpfa_word_unit.sv
`timescale 1ns / 1ps
// shared word unit: fill pattern, lowest free bit, set and clear of a map word
module bpfa_word_unit #(
  parameter int unsigned NUM_PAGES = 16384,
  parameter int unsigned WORD_AW   = 8,
  parameter int unsigned PAGE_W    = 15
) (
  input  bpfa_pkg::wu_op_e                 op_i,
  input  bpfa_pkg::word_t                  rd_word_i,
  input  logic [bpfa_pkg::BIT_IDX_W-1:0]   bit_pos_i,
  input  logic [WORD_AW-1:0]               fill_word_idx_i,
  input  logic [PAGE_W-1:0]                fill_bound_i,
  output bpfa_pkg::word_t                  wr_word_o,
  output bpfa_pkg::word_stat_t             stat_o
);

  localparam int unsigned PAD_WORD = NUM_PAGES / bpfa_pkg::WORD_BITS;
  localparam int unsigned PAD_BIT  = NUM_PAGES % bpfa_pkg::WORD_BITS;

  function automatic bpfa_pkg::word_t low_mask(input logic [bpfa_pkg::BIT_IDX_W-1:0] k);
    return ~({bpfa_pkg::WORD_BITS{1'b1}} << k);
  endfunction

  bpfa_pkg::word_t fill_word;
  bpfa_pkg::word_t lowest_zero;

  // pages below the bound are used, bits past the last page always read as used
  always_comb begin
    logic [31:0]     widx;
    logic [31:0]     bword;
    bpfa_pkg::word_t used_mask;
    bpfa_pkg::word_t pad_mask;
    widx  = 32'(fill_word_idx_i);
    bword = 32'(fill_bound_i >> bpfa_pkg::BIT_IDX_W);
    if (widx < bword) begin
      used_mask = '1;
    end else if (widx == bword) begin
      used_mask = low_mask(fill_bound_i[bpfa_pkg::BIT_IDX_W-1:0]);
    end else begin
      used_mask = '0;
    end
    if ((PAD_BIT != 0) && (widx == 32'(PAD_WORD))) begin
      pad_mask = ~low_mask(bpfa_pkg::BIT_IDX_W'(PAD_BIT));
    end else begin
      pad_mask = '0;
    end
    fill_word = used_mask | pad_mask;
  end

  // isolate the lowest clear bit, then encode it
  assign lowest_zero = ~rd_word_i & (rd_word_i + bpfa_pkg::word_t'(1));

  always_comb begin
    logic [bpfa_pkg::BIT_IDX_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < int'(bpfa_pkg::WORD_BITS); i++) begin
      pos = pos | (lowest_zero[i] ? bpfa_pkg::BIT_IDX_W'(i) : '0);
    end
    stat_o.full     = &rd_word_i;
    stat_o.zero_pos = pos;
  end

  always_comb begin
    unique case (op_i)
      bpfa_pkg::WU_FILL:       wr_word_o = fill_word;
      bpfa_pkg::WU_SET_LOWEST: wr_word_o = rd_word_i | lowest_zero;
      bpfa_pkg::WU_CLEAR_BIT:  wr_word_o = rd_word_i & ~(bpfa_pkg::word_t'(1) << bit_pos_i);
      default:                 wr_word_o = rd_word_i;
    endcase
  end

endmodule

FILE: src/bitmap_page_frame_allocator_core.sv
`timescale 1ns / 1ps
// top level of the bitmap page frame allocator: sequencer, registers, config port
//
//  channel   direction  handshake                      payload
//  request   in         in_valid_i / in_stall_o        op_i, free_address_i
//  result    out        out_valid_o / out_stall_i      status_o, page_address_o, free_count_o
//  config    in         psel/penable/pwrite, pready    paddr, pwdata, prdata
//
// the map sits in one memory of 64-bit words; every access goes through its
// write port, its registered read port and the shared word unit, one word per cycle
// init: one fill write per word, then the result
// alloc: reads words from the search hint up, skipping fully used words, and sets
// the lowest free bit of the first word that has one; out of memory when none has
// free: reads the word of the page and clears its bit if set; unknown requests are ignored
// after reset a clearing sweep over every map word runs with in_stall_o high
// a finished result waits in the output register while the next request is taken
// PAGE_BYTES is a power of two; page numbers come from shifts

module bitmap_page_frame_allocator_core #(
  parameter int unsigned NUM_PAGES  = 16384,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]    free_address_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [bpfa_pkg::ADDR_W-1:0]    page_address_o,
  output logic [bpfa_pkg::COUNT_W-1:0]   free_count_o,
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned NUM_WORDS  =
    (NUM_PAGES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
  localparam int unsigned WORD_AW    = $clog2(NUM_WORDS);
  localparam int unsigned HINT_W     = $clog2(NUM_WORDS + 1);
  localparam int unsigned PAGE_W     = $clog2(NUM_PAGES + 1);
  localparam int unsigned PIDX_W     = WORD_AW + bpfa_pkg::BIT_IDX_W;
  localparam int unsigned WIDE_W     = PIDX_W + PAGE_SHIFT + bpfa_pkg::ADDR_W;

  // sequencer states
  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ACHK = 3'd2;
  localparam logic [2:0] S_FCHK = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [WORD_AW-1:0]            sweep_q, sweep_d;
  logic                          init_run_q, init_run_d;
  logic [PAGE_W-1:0]             bound_q, bound_d;
  logic [HINT_W-1:0]             hint_q, hint_d;
  logic [bpfa_pkg::COUNT_W-1:0]  cnt_q, cnt_d;
  logic [PIDX_W-1:0]             fidx_q, fidx_d;
  logic [1:0]                    res_status_q, res_status_d;
  logic [bpfa_pkg::ADDR_W-1:0]   res_page_q, res_page_d;
  logic                          out_valid_q, out_valid_d;
  logic [1:0]                    out_status_q, out_status_d;
  logic [bpfa_pkg::ADDR_W-1:0]   out_page_q, out_page_d;
  logic [bpfa_pkg::COUNT_W-1:0]  out_count_q, out_count_d;
  logic [bpfa_pkg::ADDR_W-1:0]   kend_q;

  // memory and word unit hookup
  logic                          wr_en;
  logic [WORD_AW-1:0]            wr_addr;
  bpfa_pkg::word_t               wr_word;
  logic                          rd_en;
  logic [WORD_AW-1:0]            rd_addr;
  bpfa_pkg::word_t               rd_word;
  bpfa_pkg::wu_op_e              wu_op;
  bpfa_pkg::word_stat_t          wu_stat;

  // ---------------------------------------------------------------------------
  // config port: one register at byte 0, low address bits ignored
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : kend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kend_q <= bpfa_pkg::KERNEL_END_RESET;
    end else if (cfg_wr) begin
      kend_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // init bound: max(kernel end, 1 MiB) rounded up to a page, capped at the map
  // ---------------------------------------------------------------------------
  logic [bpfa_pkg::ADDR_W-1:0] kend_floor;
  logic [33:0]                 bound_bytes;
  logic [33:0]                 bound_pages;
  logic [PAGE_W-1:0]           init_pages;
  logic [31:0]                 init_free;

  assign kend_floor  = (kend_q < bpfa_pkg::LOW_RESERVED_BYTES) ?
                       bpfa_pkg::LOW_RESERVED_BYTES : kend_q;
  assign bound_bytes = {2'b00, kend_floor} + 34'(PAGE_BYTES - 1);
  assign bound_pages = bound_bytes >> PAGE_SHIFT;
  assign init_pages  = (bound_pages > 34'(NUM_PAGES)) ?
                       PAGE_W'(NUM_PAGES) : bound_pages[PAGE_W-1:0];
  assign init_free   = 32'(NUM_PAGES) - 32'(init_pages);

  // ---------------------------------------------------------------------------
  // free request decode: null address and pages past the map are ignored
  // ---------------------------------------------------------------------------
  logic [32:0]       free_page;
  logic              free_ok;
  logic [PIDX_W-1:0] free_idx;

  assign free_page = {1'b0, free_address_i} >> PAGE_SHIFT;
  assign free_ok   = (free_address_i != '0) && (free_page < 33'(NUM_PAGES));
  assign free_idx  = free_page[PIDX_W-1:0];

  // ---------------------------------------------------------------------------
  // alloc helpers
  // ---------------------------------------------------------------------------
  logic [HINT_W-1:0]           hint_inc;
  logic [PIDX_W-1:0]           alloc_idx;
  logic [WIDE_W-1:0]           alloc_wide;
  logic [HINT_W-1:0]           freed_word;

  assign hint_inc   = hint_q + HINT_W'(1);
  assign alloc_idx  = {hint_q[WORD_AW-1:0], wu_stat.zero_pos};
  assign alloc_wide = WIDE_W'(alloc_idx) << PAGE_SHIFT;
  assign freed_word = HINT_W'(fidx_q[PIDX_W-1:bpfa_pkg::BIT_IDX_W]);

  // ---------------------------------------------------------------------------
  // sequencer
  // words below hint_q are known to be fully used; alloc scans upward from it
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    init_run_d   = init_run_q;
    bound_d      = bound_q;
    hint_d       = hint_q;
    cnt_d        = cnt_q;
    fidx_d       = fidx_q;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_page_d   = out_page_q;
    out_count_d  = out_count_q;
    wr_en        = 1'b0;
    wr_addr      = sweep_q;
    rd_en        = 1'b0;
    rd_addr      = hint_q[WORD_AW-1:0];
    wu_op        = bpfa_pkg::WU_FILL;

    unique case (state_q)
      // write one word of the reset or init pattern per cycle
      S_FILL: begin
        wu_op   = bpfa_pkg::WU_FILL;
        wr_en   = 1'b1;
        wr_addr = sweep_q;
        if (sweep_q == WORD_AW'(NUM_WORDS - 1)) begin
          init_run_d = 1'b0;
          if (init_run_q) begin
            res_status_d = bpfa_pkg::STAT_DONE;
            res_page_d   = '0;
            state_d      = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          sweep_d = sweep_q + WORD_AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          res_page_d = '0;
          unique case (op_i)
            bpfa_pkg::OP_INIT: begin
              bound_d    = init_pages;
              sweep_d    = '0;
              init_run_d = 1'b1;
              hint_d     = HINT_W'(init_pages >> bpfa_pkg::BIT_IDX_W);
              cnt_d      = init_free[bpfa_pkg::COUNT_W-1:0];
              state_d    = S_FILL;
            end
            bpfa_pkg::OP_ALLOC: begin
              if (hint_q < HINT_W'(NUM_WORDS)) begin
                rd_en   = 1'b1;
                rd_addr = hint_q[WORD_AW-1:0];
                state_d = S_ACHK;
              end else begin
                res_status_d = bpfa_pkg::STAT_OOM;
                state_d      = S_OUT;
              end
            end
            bpfa_pkg::OP_FREE: begin
              if (free_ok) begin
                fidx_d  = free_idx;
                rd_en   = 1'b1;
                rd_addr = free_idx[PIDX_W-1:bpfa_pkg::BIT_IDX_W];
                state_d = S_FCHK;
              end else begin
                res_status_d = bpfa_pkg::STAT_IGNORED;
                state_d      = S_OUT;
              end
            end
            default: begin
              res_status_d = bpfa_pkg::STAT_IGNORED;
              state_d      = S_OUT;
            end
          endcase
        end
      end

      // word at hint_q is in the read register
      S_ACHK: begin
        wu_op = bpfa_pkg::WU_SET_LOWEST;
        if (wu_stat.full) begin
          hint_d = hint_inc;
          if (hint_inc < HINT_W'(NUM_WORDS)) begin
            rd_en   = 1'b1;
            rd_addr = hint_inc[WORD_AW-1:0];
          end else begin
            res_status_d = bpfa_pkg::STAT_OOM;
            res_page_d   = '0;
            state_d      = S_OUT;
          end
        end else begin
          wr_en        = 1'b1;
          wr_addr      = hint_q[WORD_AW-1:0];
          cnt_d        = cnt_q - bpfa_pkg::COUNT_W'(1);
          res_status_d = bpfa_pkg::STAT_DONE;
          res_page_d   = alloc_wide[bpfa_pkg::ADDR_W-1:0];
          state_d      = S_OUT;
        end
      end

      // word holding the freed page is in the read register
      S_FCHK: begin
        wu_op      = bpfa_pkg::WU_CLEAR_BIT;
        res_page_d = '0;
        state_d    = S_OUT;
        if (rd_word[fidx_q[bpfa_pkg::BIT_IDX_W-1:0]]) begin
          wr_en        = 1'b1;
          wr_addr      = fidx_q[PIDX_W-1:bpfa_pkg::BIT_IDX_W];
          cnt_d        = cnt_q + bpfa_pkg::COUNT_W'(1);
          res_status_d = bpfa_pkg::STAT_DONE;
          if (freed_word < hint_q) begin
            hint_d = freed_word;
          end
        end else begin
          res_status_d = bpfa_pkg::STAT_IGNORED;
        end
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_page_d   = res_page_q;
          out_count_d  = cnt_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      sweep_q     <= '0;
      init_run_q  <= 1'b0;
      hint_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      init_run_q  <= init_run_d;
      hint_q      <= hint_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, reset clears the bound so the first sweep writes zeros apart from the padding bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= '0;
    end else begin
      bound_q <= bound_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fidx_q       <= fidx_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    out_status_q <= out_status_d;
    out_page_q   <= out_page_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign page_address_o = out_page_q;
  assign free_count_o   = out_count_q;

  // ---------------------------------------------------------------------------
  // map memory and shared word unit
  // ---------------------------------------------------------------------------
  bpfa_map_ram #(
    .DEPTH (NUM_WORDS),
    .AW    (WORD_AW)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_word_i (wr_word),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_word_o (rd_word)
  );

  bpfa_word_unit #(
    .NUM_PAGES (NUM_PAGES),
    .WORD_AW   (WORD_AW),
    .PAGE_W    (PAGE_W)
  ) u_word (
    .op_i            (wu_op),
    .rd_word_i       (rd_word),
    .bit_pos_i       (fidx_q[bpfa_pkg::BIT_IDX_W-1:0]),
    .fill_word_idx_i (sweep_q),
    .fill_bound_i    (bound_q),
    .wr_word_o       (wr_word),
    .stat_o          (wu_stat)
  );

endmodule

FILE: src/bpfa_checker.sv
`timescale 1ns / 1ps
// port-level checks of the page frame allocator, bound to the top level
module bpfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [1:0]                     status_o,
  input logic [bpfa_pkg::ADDR_W-1:0]    page_address_o,
  input logic [bpfa_pkg::COUNT_W-1:0]   free_count_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(page_address_o) && $stable(free_count_o))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request taken while busy");

  // no result appears in the cycle right after a request
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result too early");

  // only successful allocations carry an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != bpfa_pkg::STAT_DONE) |-> page_address_o == '0)
    else $error("address on failed request");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == bpfa_pkg::STAT_DONE) ||
      (status_o == bpfa_pkg::STAT_OOM) || (status_o == bpfa_pkg::STAT_IGNORED))
    else $error("bad status code");

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (.*);
